// ----- design/bfsa_pkg.sv -----
// Shared types and constants for the bitmap free-space allocator.
`default_nettype none
package bfsa_pkg;

    localparam int MAP_BITS      = 8192;
    localparam int WORD_BITS     = 32;
    localparam int MAP_WORDS     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W       = $clog2(MAP_WORDS);
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int IDX_W         = 13;
    localparam int NUM_W         = 14;
    localparam int BLOCK_BYTES   = 1024;
    localparam int BITS_PER_BYTE = 8;

    localparam logic [NUM_W-1:0] MIN_NUMBER_RESET = NUM_W'(1);
    localparam logic [NUM_W-1:0] SCAN_LIMIT_RESET = NUM_W'(BLOCK_BYTES * BITS_PER_BYTE);
    localparam logic [NUM_W-1:0] MAP_BITS_NUM     = NUM_W'(MAP_BITS);

    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic {
        REG_MIN_NUMBER = 1'b0,
        REG_SCAN_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RMW,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] entry_idx;
    } in_t;

    typedef struct packed {
        logic [NUM_W-1:0] free_number;
        logic             found;
    } out_t;

    // Word-scan setup, held for the length of one search
    typedef struct packed {
        logic [NUM_W-1:0] lo;   // lowest zero-based index allowed
        logic [NUM_W-1:0] lim;  // one past the highest index searched
    } scan_win_t;

    typedef struct packed {
        logic             hit;
        logic [NUM_W-1:0] number;
    } scan_res_t;

endpackage
`default_nettype wire

// ----- design/bfsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/bfsa_word_scan.sv -----
// Window mask and lowest-free-bit search over one bitmap word.
`default_nettype none
module bfsa_word_scan (
    input  wire logic [bfsa_pkg::WORD_BITS-1:0] word,
    input  wire logic [bfsa_pkg::WADDR_W-1:0]   word_addr,
    input  wire bfsa_pkg::scan_win_t            win,
    output bfsa_pkg::scan_res_t                 res
);

    localparam int WW = bfsa_pkg::NUM_W - bfsa_pkg::BIT_W;

    logic [WW-1:0]                  w_ext;
    logic [WW-1:0]                  lo_w;
    logic [WW-1:0]                  hi_w;
    logic [bfsa_pkg::WORD_BITS-1:0] lo_mask;
    logic [bfsa_pkg::WORD_BITS-1:0] hi_mask;
    logic [bfsa_pkg::WORD_BITS-1:0] free_bits;
    logic [bfsa_pkg::BIT_W-1:0]     pos;
    logic [bfsa_pkg::NUM_W-1:0]     idx;

    assign w_ext = WW'(word_addr);
    assign lo_w  = win.lo[bfsa_pkg::NUM_W-1:bfsa_pkg::BIT_W];
    assign hi_w  = win.lim[bfsa_pkg::NUM_W-1:bfsa_pkg::BIT_W];

    always_comb
    begin
        if (w_ext > lo_w)
        begin
            lo_mask = '1;
        end
        else if (w_ext == lo_w)
        begin
            lo_mask = '1 << win.lo[bfsa_pkg::BIT_W-1:0];
        end
        else
        begin
            lo_mask = '0;
        end

        if (w_ext < hi_w)
        begin
            hi_mask = '1;
        end
        else if (w_ext == hi_w)
        begin
            hi_mask = ~('1 << win.lim[bfsa_pkg::BIT_W-1:0]);
        end
        else
        begin
            hi_mask = '0;
        end
    end

    assign free_bits = ~word & lo_mask & hi_mask;

    // lowest set bit wins
    always_comb
    begin
        pos = '0;
        for (int b = bfsa_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                pos = bfsa_pkg::BIT_W'(b);
            end
        end
    end

    assign idx        = {w_ext, pos};
    assign res.hit    = |free_bits;
    assign res.number = idx + bfsa_pkg::NUM_W'(1);

endmodule
`default_nettype wire

// ----- design/bitmap_free_space_allocator.sv -----
// Top level: sequencer, config registers and bitmap storage of the allocator.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_stall  | in_t  {mode, entry_idx}
//  out     | output    | out_valid/out_stall| out_t {free_number, found}
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Set/clear: accept with word read, then modify-write in ST_RMW; no result word.
// Find: scans N words (0..256), 32 bits per cycle, a rate set by the single
//   read port of the bitmap RAM; stops at the first hit.
// Reset clears a valid flag per RAM row, so no clearing pass is needed.
// The input is taken only when idle; a finished result waits in the
// output register, and a new find waits at its end while that is still stalled.
`default_nettype none
module bitmap_free_space_allocator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire bfsa_pkg::in_t              in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output bfsa_pkg::out_t                  out_data,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [bfsa_pkg::NUM_W-1:0] cfg_data
);

    localparam int AW = bfsa_pkg::WADDR_W;
    localparam int DW = bfsa_pkg::WORD_BITS;

    bfsa_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]       issue_reg, issue_next;
    logic [AW-1:0]       eval_reg, eval_next;
    logic                pend_reg, pend_next;
    logic                vld_q_reg, vld_q_next;
    logic [AW-1:0]       last_reg, last_next;
    bfsa_pkg::scan_win_t win_reg, win_next;
    logic [bfsa_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                set_reg, set_next;
    bfsa_pkg::out_t      res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    bfsa_pkg::out_t      out_data_reg, out_data_next;
    logic [bfsa_pkg::NUM_W-1:0] min_reg;
    logic [bfsa_pkg::NUM_W-1:0] limit_reg;
    logic [bfsa_pkg::MAP_WORDS-1:0] row_valid_reg;

    logic [bfsa_pkg::NUM_W-1:0] lo_c;
    logic [bfsa_pkg::NUM_W-1:0] lim_c;
    logic [bfsa_pkg::NUM_W-1:0] lim_m1;
    logic [AW-1:0]       raddr;
    logic [DW-1:0]       rdata;
    logic [DW-1:0]       word_q;
    logic                ram_we;
    logic [DW-1:0]       wdata;
    logic                in_acc;
    logic                out_free;
    bfsa_pkg::scan_res_t scan_res;

    assign lo_c   = (min_reg == '0) ? '0 : min_reg - bfsa_pkg::NUM_W'(1);
    assign lim_c  = (limit_reg > bfsa_pkg::MAP_BITS_NUM) ? bfsa_pkg::MAP_BITS_NUM : limit_reg;
    assign lim_m1 = lim_c - bfsa_pkg::NUM_W'(1);

    assign in_stall = (state_reg != bfsa_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign word_q   = rdata & {DW{vld_q_reg}};

    bfsa_ram #(
        .WIDTH(DW),
        .DEPTH(bfsa_pkg::MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx_reg[bfsa_pkg::IDX_W-1:bfsa_pkg::BIT_W]),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    bfsa_word_scan u_scan (
        .word     (word_q),
        .word_addr(eval_reg),
        .win      (win_reg),
        .res      (scan_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        eval_next      = eval_reg;
        pend_next      = pend_reg;
        vld_q_next     = vld_q_reg;
        last_next      = last_reg;
        win_next       = win_reg;
        idx_next       = idx_reg;
        set_next       = set_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        raddr          = in_data.entry_idx[bfsa_pkg::IDX_W-1:bfsa_pkg::BIT_W];
        ram_we         = 1'b0;
        wdata          = word_q;
        wdata[idx_reg[bfsa_pkg::BIT_W-1:0]] = set_reg;

        case (state_reg)
            bfsa_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_data.mode)
                        bfsa_pkg::MODE_FIND:
                        begin
                            win_next.lo  = lo_c;
                            win_next.lim = lim_c;
                            last_next    = lim_m1[bfsa_pkg::NUM_W-2:bfsa_pkg::BIT_W];
                            issue_next   = '0;
                            pend_next    = 1'b0;
                            if (lim_c == '0)
                            begin
                                res_next   = '0;
                                state_next = bfsa_pkg::ST_FIN;
                            end
                            else
                            begin
                                state_next = bfsa_pkg::ST_SCAN;
                            end
                        end
                        bfsa_pkg::MODE_SET, bfsa_pkg::MODE_CLEAR:
                        begin
                            idx_next   = in_data.entry_idx;
                            set_next   = (in_data.mode == bfsa_pkg::MODE_SET);
                            vld_q_next = row_valid_reg[raddr];
                            state_next = bfsa_pkg::ST_RMW;
                        end
                        default:
                        begin
                            state_next = bfsa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bfsa_pkg::ST_SCAN:
            begin
                // one word issued per cycle, evaluated the cycle after
                raddr      = issue_reg;
                issue_next = issue_reg + AW'(1);
                eval_next  = issue_reg;
                pend_next  = 1'b1;
                vld_q_next = row_valid_reg[raddr];
                if (pend_reg)
                begin
                    if (scan_res.hit)
                    begin
                        res_next.free_number = scan_res.number;
                        res_next.found       = 1'b1;
                        state_next           = bfsa_pkg::ST_FIN;
                    end
                    else if (eval_reg == last_reg)
                    begin
                        res_next   = '0;
                        state_next = bfsa_pkg::ST_FIN;
                    end
                end
            end
            bfsa_pkg::ST_RMW:
            begin
                ram_we     = 1'b1;
                state_next = bfsa_pkg::ST_IDLE;
            end
            bfsa_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = bfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfsa_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            min_reg       <= bfsa_pkg::MIN_NUMBER_RESET;
            limit_reg     <= bfsa_pkg::SCAN_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                row_valid_reg[idx_reg[bfsa_pkg::IDX_W-1:bfsa_pkg::BIT_W]] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    bfsa_pkg::REG_MIN_NUMBER: min_reg   <= cfg_data;
                    bfsa_pkg::REG_SCAN_LIMIT: limit_reg <= cfg_data;
                    default:                  min_reg   <= min_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        eval_reg     <= eval_next;
        vld_q_reg    <= vld_q_next;
        last_reg     <= last_next;
        win_reg      <= win_next;
        idx_reg      <= idx_next;
        set_reg      <= set_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- bench/tb_bitmap_free_space_allocator.sv -----
// Testbench for the allocator: directed and random set/clear/find traffic against a bitmap predictor.
`timescale 1ns / 1ps
module tb_bitmap_free_space_allocator;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         RANDOM_WORDS  = 1900;

    typedef struct packed {
        bfsa_pkg::in_t word;
        logic          drain;    // marker: hold the sender until every find has answered
    } send_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_LONG
    } stall_style_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    bfsa_pkg::in_t              in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    bfsa_pkg::out_t             out_data;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [bfsa_pkg::NUM_W-1:0] cfg_data  = '0;

    // predictor state
    logic [bfsa_pkg::MAP_BITS-1:0] usage_map = '0;
    logic [bfsa_pkg::NUM_W-1:0]    min_entry = bfsa_pkg::MIN_NUMBER_RESET;
    logic [bfsa_pkg::NUM_W-1:0]    scan_bits = bfsa_pkg::SCAN_LIMIT_RESET;
    bfsa_pkg::out_t                expected_free_q[$];
    bfsa_pkg::out_t                want;

    send_t        send_q[$];
    logic         word_taken  = 1'b0;
    logic         holding     = 1'b0;
    int           burst_left  = 0;
    int           gap_left    = 0;
    int           stall_left  = 0;
    stall_style_t stall_style = STALL_NONE;
    int           errors      = 0;

    bitmap_free_space_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bfsa_pkg::out_t first_free_entry(
        input logic [bfsa_pkg::NUM_W-1:0] lo_num,
        input logic [bfsa_pkg::NUM_W-1:0] limit_bits);
        bfsa_pkg::out_t r;
        int             span;
        r = '0;
        span = (limit_bits > bfsa_pkg::MAP_BITS) ? bfsa_pkg::MAP_BITS : int'(limit_bits);
        for (int i = 0; i < span; i++)
        begin
            if (!usage_map[i] && (i + 1) >= lo_num)
            begin
                r.free_number = bfsa_pkg::NUM_W'(i + 1);
                r.found       = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    // monitor: track accepted words and config writes, check result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (cfg_we)
            begin
                if (cfg_index == bfsa_pkg::REG_MIN_NUMBER)
                    min_entry = cfg_data;
                else
                    scan_bits = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.mode)
                    bfsa_pkg::MODE_FIND:
                        expected_free_q.push_back(first_free_entry(min_entry, scan_bits));
                    bfsa_pkg::MODE_SET:   usage_map[in_data.entry_idx] = 1'b1;
                    bfsa_pkg::MODE_CLEAR: usage_map[in_data.entry_idx] = 1'b0;
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_free_q.size() == 0)
                begin
                    $display("%0t: unexpected word: free_number=%0d found=%0b",
                             $time, out_data.free_number, out_data.found);
                    errors++;
                end
                else
                begin
                    want = expected_free_q.pop_front();
                    if (out_data.free_number != want.free_number)
                    begin
                        $display("%0t: free_number mismatch: expected %0d, actual %0d",
                                 $time, want.free_number, out_data.free_number);
                        errors++;
                    end
                    if (out_data.found != want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, out_data.found);
                        errors++;
                    end
                end
            end
        end
    end

    // driver: bursts of words with random gaps
    always @(negedge clk)
    begin : drive
        send_t nxt;
        logic  v;
        v = in_valid;
        if (rst_n && !(in_valid && !word_taken))
        begin
            v = 1'b0;
            if (holding)
            begin
                if (expected_free_q.size() == 0)
                    holding = 1'b0;
            end
            else if (gap_left > 0)
                gap_left = gap_left - 1;
            else if (send_q.size() > 0)
            begin
                nxt = send_q.pop_front();
                if (nxt.drain)
                    holding = 1'b1;
                else
                begin
                    v = 1'b1;
                    in_data <= nxt.word;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
        in_valid <= v;
    end

    // receiver stall pattern, style changes every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_left  = $urandom_range(10, 150);
        end
        stall_left = stall_left - 1;
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
            STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
            default:     out_stall <= (stall_left % 16) < 10;
        endcase
    end

    task automatic push_word(input logic [1:0] mode, input logic [bfsa_pkg::IDX_W-1:0] idx);
        send_t s;
        s.word.mode      = mode;
        s.word.entry_idx = idx;
        s.drain          = 1'b0;
        send_q.push_back(s);
    endtask

    task automatic push_drain();
        send_t s;
        s       = '0;
        s.drain = 1'b1;
        send_q.push_back(s);
    endtask

    // block idle: everything sent, every find answered, set/clear settled
    task automatic wait_quiet();
        while (send_q.size() != 0 || in_valid || holding || expected_free_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bfsa_pkg::reg_idx_t idx,
                             input logic [bfsa_pkg::NUM_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stim
        int                         sent;
        int                         phase_len;
        int                         phase_sent;
        int                         window;
        int                         n;
        int                         base;
        logic [bfsa_pkg::NUM_W-1:0] lo;
        logic [bfsa_pkg::NUM_W-1:0] lim;
        logic [bfsa_pkg::NUM_W-1:0] hint;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, all modes, unused mode, index extremes
        push_word(bfsa_pkg::MODE_FIND, '0);
        push_word(bfsa_pkg::MODE_SET, '0);
        push_word(bfsa_pkg::MODE_SET, 13'd1);
        push_word(bfsa_pkg::MODE_FIND, 13'h1FFF);
        push_word(MODE_UNUSED, 13'd2);
        push_word(bfsa_pkg::MODE_FIND, '0);
        push_word(bfsa_pkg::MODE_SET, 13'h1FFF);
        push_word(bfsa_pkg::MODE_CLEAR, 13'd1);
        push_word(bfsa_pkg::MODE_FIND, 13'h0AAA);
        push_word(bfsa_pkg::MODE_CLEAR, '0);
        push_word(bfsa_pkg::MODE_FIND, 13'h1555);
        wait_quiet();
        // minimum at the top entry, which is used and then freed
        write_reg(bfsa_pkg::REG_MIN_NUMBER, bfsa_pkg::MAP_BITS_NUM);
        push_word(bfsa_pkg::MODE_FIND, '0);
        push_word(bfsa_pkg::MODE_CLEAR, 13'h1FFF);
        push_word(bfsa_pkg::MODE_FIND, '0);
        wait_quiet();
        // minimum of zero acts like one
        write_reg(bfsa_pkg::REG_MIN_NUMBER, '0);
        push_word(bfsa_pkg::MODE_FIND, '0);
        wait_quiet();
        // zero scan limit
        write_reg(bfsa_pkg::REG_SCAN_LIMIT, '0);
        push_word(bfsa_pkg::MODE_FIND, '0);
        wait_quiet();
        // scan limit above the map, minimum beyond the map
        write_reg(bfsa_pkg::REG_SCAN_LIMIT, '1);
        write_reg(bfsa_pkg::REG_MIN_NUMBER, '1);
        push_word(bfsa_pkg::MODE_FIND, '0);
        wait_quiet();
        // one-bit scan limit, bit used
        write_reg(bfsa_pkg::REG_MIN_NUMBER, 14'd1);
        write_reg(bfsa_pkg::REG_SCAN_LIMIT, 14'd1);
        push_word(bfsa_pkg::MODE_SET, '0);
        push_word(bfsa_pkg::MODE_FIND, '0);
        push_word(bfsa_pkg::MODE_CLEAR, '0);
        push_word(bfsa_pkg::MODE_FIND, '0);

        // random phases
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            wait_quiet();
            case ($urandom_range(0, 3))
                0:       window = 16;
                1:       window = 64;
                2:       window = 512;
                default: window = bfsa_pkg::MAP_BITS;
            endcase
            case ($urandom_range(0, 5))
                0:       lo = '0;
                1:       lo = 14'd1;
                2:       lo = bfsa_pkg::NUM_W'($urandom_range(1, 64));
                3:       lo = bfsa_pkg::NUM_W'($urandom_range(1, bfsa_pkg::MAP_BITS));
                4:       lo = bfsa_pkg::NUM_W'($urandom_range(bfsa_pkg::MAP_BITS - 2, 16383));
                default: lo = bfsa_pkg::NUM_W'($urandom_range(1, window));
            endcase
            case ($urandom_range(0, 9))
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = bfsa_pkg::MAP_BITS_NUM;
                3:       lim = bfsa_pkg::NUM_W'($urandom_range(1, bfsa_pkg::MAP_BITS));
                default: lim = bfsa_pkg::NUM_W'(window + $urandom_range(0, 40));
            endcase
            write_reg(bfsa_pkg::REG_MIN_NUMBER, lo);
            write_reg(bfsa_pkg::REG_SCAN_LIMIT, lim);
            if (lo == '0)
                hint = '0;
            else if (lo > bfsa_pkg::MAP_BITS_NUM)
                hint = bfsa_pkg::NUM_W'(bfsa_pkg::MAP_BITS - 1);
            else
                hint = lo - bfsa_pkg::NUM_W'(1);

            phase_len  = $urandom_range(120, 260);
            phase_sent = 0;
            while (phase_sent < phase_len)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        // sequential allocation run, then a lookup
                        n    = $urandom_range(1, 48);
                        base = $urandom_range(0, 1) ? int'(hint) : $urandom_range(0, window - 1);
                        for (int k = 0; k < n; k++)
                            push_word(bfsa_pkg::MODE_SET, bfsa_pkg::IDX_W'(base + k));
                        push_word(bfsa_pkg::MODE_FIND, bfsa_pkg::IDX_W'($urandom));
                        phase_sent += n + 1;
                    end
                    3, 4:
                    begin
                        // free a few entries, then a lookup
                        n = $urandom_range(1, 6);
                        for (int k = 0; k < n; k++)
                            push_word(bfsa_pkg::MODE_CLEAR,
                                      bfsa_pkg::IDX_W'($urandom_range(0, window - 1)));
                        push_word(bfsa_pkg::MODE_FIND, bfsa_pkg::IDX_W'($urandom));
                        phase_sent += n + 1;
                    end
                    5, 6:
                    begin
                        push_word(2'($urandom_range(0, 2)),
                                  bfsa_pkg::IDX_W'($urandom_range(0, window - 1)));
                        phase_sent++;
                    end
                    7:
                    begin
                        // noise over the full index range, unused mode included
                        n = $urandom_range(0, 3);
                        push_word(2'(n), bfsa_pkg::IDX_W'($urandom));
                        if (2'(n) != MODE_UNUSED)
                            phase_sent++;
                    end
                    8:
                    begin
                        n = $urandom_range(1, 4);
                        for (int k = 0; k < n; k++)
                            push_word(bfsa_pkg::MODE_FIND, bfsa_pkg::IDX_W'($urandom));
                        phase_sent += n;
                    end
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0)
                            push_drain();
                        push_word(bfsa_pkg::MODE_FIND, bfsa_pkg::IDX_W'($urandom));
                        phase_sent++;
                    end
                endcase
            end
            sent += phase_sent;
        end

        wait_quiet();
        repeat (32) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
design/bfsa_pkg.sv
design/bfsa_ram.sv
design/bfsa_word_scan.sv
design/bitmap_free_space_allocator.sv
bench/tb_bitmap_free_space_allocator.sv
